>>> design/sacl_pkg.sv
// Shared constants and helpers for the set-associative cache lookup.
`default_nettype none

package sacl_pkg;

	// Address, age and hit/miss counters are all one 32-bit word.
	localparam int WORD_W = 32;
	localparam logic [WORD_W-1:0] WORD_MAX = 32'hFFFF_FFFF;

	// Widths of the reported way and set fields.
	localparam int WAY_OUT_W = 2;
	localparam int SET_OUT_W = 3;

	// Add one, hold at all ones.
	function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
		return (v == WORD_MAX) ? v : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

>>> design/sacl_row_mem.sv
// Set row storage: one write port, one read port with registered read data.
`default_nettype none

module sacl_row_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int DW    = 236
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/sacl_way_select.sv
// Tag compare, LRU victim search and row update for one set.
`default_nettype none

module sacl_way_select #(
	parameter int NUM_WAYS = 4,
	parameter int TAG_W    = 26,
	parameter int WAY_W    = 2
) (
	input  wire logic [TAG_W-1:0]                         tag,
	input  wire logic [NUM_WAYS-1:0]                      row_valid,
	input  wire logic [NUM_WAYS-1:0][sacl_pkg::WORD_W-1:0] row_age,
	input  wire logic [NUM_WAYS-1:0][TAG_W-1:0]           row_tag,
	output logic                                          hit,
	output logic      [WAY_W-1:0]                         way,
	output logic      [NUM_WAYS-1:0]                      new_valid,
	output logic      [NUM_WAYS-1:0][sacl_pkg::WORD_W-1:0] new_age,
	output logic      [NUM_WAYS-1:0][TAG_W-1:0]           new_tag
);

	// Victim search tree, padded to a power of two; heap layout, root at 0.
	localparam int LEAVES = 1 << $clog2(NUM_WAYS);
	localparam int NODES  = 2 * LEAVES - 1;

	logic [NUM_WAYS-1:0]         match;
	logic [WAY_W-1:0]            hit_way;
	logic [sacl_pkg::WORD_W-1:0] nd_age [NODES];
	logic [WAY_W-1:0]            nd_idx [NODES];

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			match[w] = row_valid[w] && (row_tag[w] == tag);
		end
	end

	// Lowest-numbered matching way.
	always_comb begin
		hit_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
		end
	end

	// Oldest way; the lower index keeps ties. Padding leaves read as age zero
	// and so never beat a real way.
	for (genvar n = 0; n < NODES; n++) begin : g_node
		if (n >= LEAVES - 1) begin : g_leaf
			if (n - (LEAVES - 1) < NUM_WAYS) begin : g_real
				assign nd_age[n] = row_age[n - (LEAVES - 1)];
			end else begin : g_pad
				assign nd_age[n] = '0;
			end
			assign nd_idx[n] = WAY_W'(n - (LEAVES - 1));
		end else begin : g_inner
			assign nd_age[n] = (nd_age[2*n+2] > nd_age[2*n+1]) ? nd_age[2*n+2]
			                                                   : nd_age[2*n+1];
			assign nd_idx[n] = (nd_age[2*n+2] > nd_age[2*n+1]) ? nd_idx[2*n+2]
			                                                   : nd_idx[2*n+1];
		end
	end

	assign hit = |match;
	assign way = hit ? hit_way : nd_idx[0];

	// Age every way, zero the accessed one, refill the victim on a miss.
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (WAY_W'(w) == way) begin
				new_age[w]   = '0;
				new_valid[w] = 1'b1;
				new_tag[w]   = hit ? row_tag[w] : tag;
			end else begin
				new_age[w]   = sacl_pkg::sat_inc(row_age[w]);
				new_valid[w] = row_valid[w];
				new_tag[w]   = row_tag[w];
			end
		end
	end

endmodule

`default_nettype wire

>>> design/set_assoc_cache_lru_lookup.sv
// Top level of the set-associative cache tag lookup with LRU replacement.
// Each beat on the input channel carries one 32-bit byte address. The address
// splits into a byte offset of floor(log2(LINE_BYTES)) bits, a set index of
// floor(log2(NUM_SETS)) bits and the remaining high bits as tag. A valid way
// of the set with the same tag is a hit; otherwise the way with the largest
// age (lowest index on ties) is refilled with the tag. Every access ages all
// ways of its set by one, saturating, and zeroes the accessed way. Each beat
// returns one result beat with hit, way, set index and the running hit and
// miss totals, which saturate at all ones. Throughput is one address per
// cycle while the output is not stalled; a result passes from the lookup
// stage into the output register when the lookup advances, and is held there
// while the output is stalled. The rate is set by the set row memory: each
// access reads its row through the registered read port at accept and writes
// it back through the write port when the lookup advances, with a bypass
// register covering a back-to-back access to the same set. After reset a
// clearing pass walks all 2**floor(log2(NUM_SETS)) rows of the row memory,
// one set per cycle; in_stall stays high until it ends.
`default_nettype none

module set_assoc_cache_lru_lookup #(
	parameter int NUM_SETS   = 8,
	parameter int NUM_WAYS   = 4,
	parameter int LINE_BYTES = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [sacl_pkg::WORD_W-1:0]       address,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   hit,
	output logic      [sacl_pkg::WAY_OUT_W-1:0]    way,
	output logic      [sacl_pkg::SET_OUT_W-1:0]    set_number,
	output logic      [sacl_pkg::WORD_W-1:0]       hit_count,
	output logic      [sacl_pkg::WORD_W-1:0]       miss_count
);

	localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
	localparam int SET_BITS = $clog2(NUM_SETS + 1) - 1;
	localparam int NUM_ROWS = 1 << SET_BITS;
	localparam int ROW_AW   = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = sacl_pkg::WORD_W - OFF_BITS - SET_BITS;
	localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int ROW_W    = NUM_WAYS * (1 + sacl_pkg::WORD_W + TAG_W);
	localparam logic [ROW_AW-1:0] SET_MASK = ROW_AW'((64'd1 << SET_BITS) - 64'd1);
	localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(NUM_ROWS - 1);

	// Address split for the incoming beat.
	logic [ROW_AW-1:0] in_set;
	logic [TAG_W-1:0]  in_tag;
	logic              in_accept;

	// Lookup stage.
	logic              s1_valid_q;
	logic [ROW_AW-1:0] set_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic              s1_adv;

	// Row memory and bypass of the last row written.
	logic [ROW_W-1:0]  rd_row;
	logic [ROW_W-1:0]  row_sel;
	logic [ROW_AW-1:0] byp_set_q;
	logic [ROW_W-1:0]  byp_row_q;
	logic              mem_we;
	logic [ROW_AW-1:0] mem_waddr;
	logic [ROW_W-1:0]  mem_wdata;

	logic [NUM_WAYS-1:0]                      row_valid;
	logic [NUM_WAYS-1:0][sacl_pkg::WORD_W-1:0] row_age;
	logic [NUM_WAYS-1:0][TAG_W-1:0]           row_tag;
	logic [NUM_WAYS-1:0]                      new_valid;
	logic [NUM_WAYS-1:0][sacl_pkg::WORD_W-1:0] new_age;
	logic [NUM_WAYS-1:0][TAG_W-1:0]           new_tag;
	logic [ROW_W-1:0]                         new_row;
	logic                                     hit_w;
	logic [WAY_W-1:0]                         way_w;

	// Running totals.
	logic [sacl_pkg::WORD_W-1:0] hits_q;
	logic [sacl_pkg::WORD_W-1:0] misses_q;
	logic [sacl_pkg::WORD_W-1:0] hits_nxt;
	logic [sacl_pkg::WORD_W-1:0] misses_nxt;

	// Clearing pass after reset.
	logic              clr_busy_q;
	logic [ROW_AW-1:0] clr_idx_q;

	// Result stage.
	logic s2_valid_q;

	assign in_set = ROW_AW'(address >> OFF_BITS) & SET_MASK;
	assign in_tag = TAG_W'(address >> (OFF_BITS + SET_BITS));

	// Advance the lookup stage whenever the result register is free or drains;
	// hold the input while the stage is full and stuck or the clear is running.
	assign s1_adv    = s1_valid_q && (!s2_valid_q || !out_stall);
	assign in_stall  = clr_busy_q || (s1_valid_q && !s1_adv);
	assign in_accept = in_valid && !in_stall;

	sacl_row_mem #(
		.DEPTH (NUM_ROWS),
		.AW    (ROW_AW),
		.DW    (ROW_W)
	) u_row_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_accept),
		.raddr (in_set),
		.rdata (rd_row)
	);

	// The bypass always mirrors the memory contents of its set, so take it
	// whenever the sets agree: it covers the write that raced our read.
	assign row_sel = (byp_set_q == set_s1) ? byp_row_q : rd_row;
	assign {row_valid, row_age, row_tag} = row_sel;

	sacl_way_select #(
		.NUM_WAYS (NUM_WAYS),
		.TAG_W    (TAG_W),
		.WAY_W    (WAY_W)
	) u_way_select (
		.tag       (tag_s1),
		.row_valid (row_valid),
		.row_age   (row_age),
		.row_tag   (row_tag),
		.hit       (hit_w),
		.way       (way_w),
		.new_valid (new_valid),
		.new_age   (new_age),
		.new_tag   (new_tag)
	);

	assign new_row = {new_valid, new_age, new_tag};

	// Write back the updated row, or zero a row during the clearing pass.
	assign mem_we    = clr_busy_q || s1_adv;
	assign mem_waddr = clr_busy_q ? clr_idx_q : set_s1;
	assign mem_wdata = clr_busy_q ? '0 : new_row;

	assign hits_nxt   = hit_w ? sacl_pkg::sat_inc(hits_q) : hits_q;
	assign misses_nxt = hit_w ? misses_q : sacl_pkg::sat_inc(misses_q);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			hits_q     <= '0;
			misses_q   <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST_ROW) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
				hits_q     <= hits_nxt;
				misses_q   <= misses_nxt;
			end else if (!out_stall) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			set_s1 <= in_set;
			tag_s1 <= in_tag;
		end
		if (mem_we) begin
			byp_set_q <= mem_waddr;
			byp_row_q <= mem_wdata;
		end
		if (s1_adv) begin
			hit        <= hit_w;
			way        <= sacl_pkg::WAY_OUT_W'(way_w);
			set_number <= sacl_pkg::SET_OUT_W'(set_s1);
			hit_count  <= hits_nxt;
			miss_count <= misses_nxt;
		end
	end

	assign out_valid = s2_valid_q;

	// No address may enter while the row memory is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_accept)
		else $error("address accepted during clearing pass");

	// A hit must point at a valid way holding the looked-up tag.
	a_hit_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && hit_w) |-> (row_valid[way_w] && (row_tag[way_w] == tag_s1)))
		else $error("hit on a way without a matching valid tag");

	// The accessed way leaves the lookup valid, with its age zeroed.
	a_access_resets_age: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |-> (new_valid[way_w] && (new_age[way_w] == '0)))
		else $error("accessed way not made youngest");

	// A hit below saturation advances the hit total by exactly one.
	a_hit_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && hit_w && (hits_q != sacl_pkg::WORD_MAX)) |=>
		(hits_q == $past(hits_q) + 1'b1))
		else $error("hit total did not advance on a hit");

	// A new result beat only ever follows a lookup that advanced.
	a_result_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s2_valid_q) |-> $past(s1_adv))
		else $error("result appeared without a lookup");

endmodule

`default_nettype wire

>>> bench/set_assoc_cache_lru_lookup_tb.sv
// Self-checking testbench for the set-associative cache tag lookup with LRU refill.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_tb;

	// Geometry under test: 8 sets, 4 ways, 8-byte lines.
	localparam int SETS     = 8;
	localparam int WAYS     = 4;
	localparam int LINE_B   = 8;
	localparam int OFFSET_W = 3;
	localparam int SET_W    = 3;
	localparam int TAG_W    = sacl_pkg::WORD_W - OFFSET_W - SET_W;
	localparam int POOL_N   = 6;
	localparam int RANDOM_ACCESSES = 1500;

	typedef logic [sacl_pkg::WORD_W-1:0] word_t;

	// One lookup outcome as the block reports it.
	typedef struct packed {
		logic                            hit;
		logic [sacl_pkg::WAY_OUT_W-1:0]  way;
		logic [sacl_pkg::SET_OUT_W-1:0]  set_number;
		word_t                           hit_count;
		word_t                           miss_count;
	} lookup_result_t;

	// Shadow copy of the tag array and ages; predicts each lookup outcome
	// and matches result beats against them in order.
	class lookup_tracker;
		logic [TAG_W-1:0] line_tag [SETS][WAYS];
		bit               line_valid [SETS][WAYS];
		word_t            line_age [SETS][WAYS];
		word_t            hits;
		word_t            misses;
		lookup_result_t   pending_lookups[$];
		int               errors;

		function new();
			foreach (line_valid[s, w]) begin
				line_tag[s][w]   = '0;
				line_valid[s][w] = 1'b0;
				line_age[s][w]   = '0;
			end
			hits   = '0;
			misses = '0;
			errors = 0;
		endfunction

		function void note_access(word_t addr);
			int               s;
			int               pick;
			bit               found;
			logic [TAG_W-1:0] t;
			lookup_result_t   r;
			s     = addr[OFFSET_W +: SET_W];
			t     = addr[sacl_pkg::WORD_W-1 -: TAG_W];
			pick  = 0;
			found = 1'b0;
			for (int w = 0; w < WAYS; w++) begin
				if (!found && line_valid[s][w] && line_tag[s][w] == t) begin
					found = 1'b1;
					pick  = w;
				end
			end
			if (found) begin
				hits = (hits == sacl_pkg::WORD_MAX) ? hits : hits + 1;
			end else begin
				misses = (misses == sacl_pkg::WORD_MAX) ? misses : misses + 1;
				// Oldest way goes; strict compare keeps the lowest index on ties.
				for (int w = 1; w < WAYS; w++)
					if (line_age[s][w] > line_age[s][pick])
						pick = w;
				line_tag[s][pick]   = t;
				line_valid[s][pick] = 1'b1;
			end
			for (int w = 0; w < WAYS; w++)
				if (line_age[s][w] != sacl_pkg::WORD_MAX)
					line_age[s][w] = line_age[s][w] + 1;
			line_age[s][pick] = '0;
			r.hit        = found;
			r.way        = pick[sacl_pkg::WAY_OUT_W-1:0];
			r.set_number = s[sacl_pkg::SET_OUT_W-1:0];
			r.hit_count  = hits;
			r.miss_count = misses;
			pending_lookups.push_back(r);
		endfunction

		function void compare_field(string name, word_t exp_v, word_t got_v);
			if (got_v !== exp_v) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_lookup(lookup_result_t got);
			lookup_result_t exp_r;
			if (pending_lookups.size() == 0) begin
				$display("%0t: result beat with no lookup outstanding, got %p", $time, got);
				errors++;
				return;
			end
			exp_r = pending_lookups.pop_front();
			compare_field("hit", word_t'(exp_r.hit), word_t'(got.hit));
			compare_field("way", word_t'(exp_r.way), word_t'(got.way));
			compare_field("set_number", word_t'(exp_r.set_number), word_t'(got.set_number));
			compare_field("hit_count", exp_r.hit_count, got.hit_count);
			compare_field("miss_count", exp_r.miss_count, got.miss_count);
		endfunction

		function int outstanding();
			return pending_lookups.size();
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	word_t address = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	logic                            hit;
	logic [sacl_pkg::WAY_OUT_W-1:0]  way;
	logic [sacl_pkg::SET_OUT_W-1:0]  set_number;
	word_t                           hit_count;
	word_t                           miss_count;

	lookup_tracker tracker = new();

	// Quiet-stretch flags, one per side; while set, that side never idles.
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;

	logic [TAG_W-1:0] tag_pool [SETS][POOL_N];

	set_assoc_cache_lru_lookup #(
		.NUM_SETS  (SETS),
		.NUM_WAYS  (WAYS),
		.LINE_BYTES(LINE_B)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.address   (address),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.way       (way),
		.set_number(set_number),
		.hit_count (hit_count),
		.miss_count(miss_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Draw a random idle count; now and then flip into or out of a
	// stretch with no idling at all.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 49) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic word_t make_addr(logic [TAG_W-1:0] t, int s, int off);
		return {t, s[SET_W-1:0], off[OFFSET_W-1:0]};
	endfunction

	// Present one address beat and hold it until the block takes it. When the
	// gap is zero, in_valid stays high from the previous beat: only one
	// assignment per edge, so the beat runs back to back.
	task automatic send_access(word_t a);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			address  <= $urandom;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		address  <= a;
		// Sample in_stall as it stood before the edge: that decides acceptance.
		do @(posedge clk); while (in_stall);
		tracker.note_access(a);
	endtask

	// Result side: stall for a drawn number of cycles, then take one beat.
	initial begin : take_results
		int             n;
		lookup_result_t got;
		@(posedge arst_n);
		forever begin
			n = draw_wait(take_calm);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got.hit        = hit;
			got.way        = way;
			got.set_number = set_number;
			got.hit_count  = hit_count;
			got.miss_count = miss_count;
			tracker.check_lookup(got);
		end
	end

	// Watchdog: a slow correct run needs well under 1 ms.
	initial begin : watchdog
		#5_000_000;
		$display("set_assoc_cache_lru_lookup_tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		int   s;
		int   k;
		word_t a;

		foreach (tag_pool[i, j])
			tag_pool[i][j] = $urandom;

		// Hold reset, then release it; the block clears its rows on its own
		// and keeps in_stall high meanwhile.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill set 0 with ways 0..3, hit in it, then force evictions
		// so that the oldest way goes and a re-fetched tag lands elsewhere.
		send_access(32'h0000_0000);                  // miss, all ages tied: way 0
		send_access(32'h0000_0007);                  // hit, same line, top offset
		send_access(make_addr(26'd1, 0, 0));         // miss, way 1
		send_access(make_addr(26'd2, 0, 3));         // miss, way 2
		send_access(make_addr(26'd3, 0, 5));         // miss, way 3
		send_access(make_addr(26'd1, 0, 1));         // hit way 1
		send_access(make_addr(26'd4, 0, 2));         // evict way 0
		send_access(32'h0000_0000);                  // tag 0 gone: miss, evict way 2
		send_access(make_addr(26'd1, 0, 6));         // still present
		send_access(32'hFFFF_FFFF);                  // all-ones tag, set 7
		send_access(32'hFFFF_FFF8);                  // hit, offset zero
		send_access(32'hFFFF_FFC0);                  // all-ones tag, set 0
		send_access(32'h0000_0038);                  // tag 0, set 7
		send_access(32'hAAAA_AAAA);
		send_access(32'h5555_5555);
		send_access(32'hAAAA_AAAA);                  // hit
		send_access(32'h8000_0000);                  // top tag bit only
		send_access(32'h0000_0040);                  // lowest tag bit only
		send_access(32'h0000_0008);                  // set 1, tag 0
		send_access(32'h8000_0000);                  // hit
		for (int i = 0; i < 5; i++)                  // overflow set 4 by one line
			send_access(make_addr(TAG_W'(i + 100), 4, i));

		// Random: mostly a small tag pool per set, so hits and evictions mix;
		// the rest are fully random addresses.
		for (int i = 0; i < RANDOM_ACCESSES; i++) begin
			if ($urandom_range(0, 99) < 15) begin
				a = $urandom;
			end else begin
				s = $urandom_range(0, SETS - 1);
				k = $urandom_range(0, POOL_N - 1);
				a = make_addr(tag_pool[s][k], s, $urandom_range(0, LINE_B - 1));
			end
			send_access(a);
		end
		in_valid <= 1'b0;

		// Drain: wait for every expected beat, then a few more edges to catch
		// anything extra.
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (tracker.errors == 0) begin
			$display("set_assoc_cache_lru_lookup_tb: done, clean");
		end else begin
			$display("set_assoc_cache_lru_lookup_tb: done, errors");
		end
		$finish;
	end

endmodule

>>> set_assoc_cache_lru_lookup.f
design/sacl_pkg.sv
design/sacl_row_mem.sv
design/sacl_way_select.sv
design/set_assoc_cache_lru_lookup.sv
bench/set_assoc_cache_lru_lookup_tb.sv
